### rtl/core/slcfp_pkg.sv
// Shared constants and types for the sync/length/checksum frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package slcfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int BIDX_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 7'd64;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_DEV,
        PH_SYS,
        PH_MSG,
        PH_LEN,
        PH_DATA,
        PH_CSUM
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_MAX_LEN     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] dev;
        logic [BYTE_W-1:0] sys;
        logic [BYTE_W-1:0] msg;
        logic [LEN_W-1:0]  len;
    } t_frame_hdr;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

endpackage

`default_nettype wire

### rtl/core/slcfp_if.sv
// Valid/ready channel interfaces for received bytes and replayed results.
// Depends on slcfp_pkg.
`default_nettype none

interface slcfp_in_if;
    import slcfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfp_out_if;
    import slcfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] device_id;
    logic [BYTE_W-1:0] system_id;
    logic [BYTE_W-1:0] message_id;
    logic [LEN_W-1:0]  payload_len;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_byte;
    logic              last;
    modport source (output valid, output device_id, output system_id, output message_id,
                    output payload_len, output byte_index, output payload_byte,
                    output has_byte, output last, input ready);
    modport sink   (input valid, input device_id, input system_id, input message_id,
                    input payload_len, input byte_index, input payload_byte,
                    input has_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/slcfp_payload_ram.sv
// Payload byte store: one write port, one read port with registered data.
// Depends on slcfp_pkg.
`default_nettype none

module slcfp_payload_ram (
    input  wire logic                      i_clk,
    input  wire slcfp_pkg::t_ram_wr        i_wr,
    input  wire slcfp_pkg::t_ram_rd        i_rd,
    output logic [slcfp_pkg::BYTE_W-1:0]   o_rd_data
);
    import slcfp_pkg::*;

    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read data holds while no read is issued; the replay relies on that.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rd_data <= r_mem[i_rd.addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/slcfp_rx_fsm.sv
// Receive state machine: sync hunt, header capture, payload store writes, checksum.
// Depends on slcfp_pkg.
`default_nettype none

module slcfp_rx_fsm (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_acc,
    input  wire logic [slcfp_pkg::BYTE_W-1:0] i_byte,
    input  wire slcfp_pkg::t_cfg           i_cfg,
    output slcfp_pkg::t_ram_wr             o_wr,
    output logic                           o_start,
    output slcfp_pkg::t_frame_hdr          o_hdr
);
    import slcfp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    t_frame_hdr        r_hdr, n_hdr;

    logic [LEN_W-1:0]  limit;
    logic              len_bad;
    logic [LEN_W-1:0]  cnt_inc;

    assign limit   = (i_cfg.max_len > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : i_cfg.max_len;
    assign len_bad = i_byte > {1'b0, limit};
    assign cnt_inc = r_cnt + LEN_W'(1);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_acc) begin
            case (r_phase)
                PH_SYNC1: if (i_byte == i_cfg.sync_first) n_phase = PH_SYNC2;
                PH_SYNC2: n_phase = (i_byte == i_cfg.sync_second) ? PH_DEV : PH_SYNC1;
                PH_DEV:   n_phase = PH_SYS;
                PH_SYS:   n_phase = PH_MSG;
                PH_MSG:   n_phase = PH_LEN;
                PH_LEN: begin
                    if (len_bad) begin
                        n_phase = PH_SYNC1;
                    end else if (i_byte == '0) begin
                        n_phase = PH_CSUM;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA:  if (cnt_inc >= r_hdr.len) n_phase = PH_CSUM;
                PH_CSUM:  n_phase = PH_SYNC1;
                default:  n_phase = PH_SYNC1;
            endcase
        end
    end

    // Header, count and running checksum.
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_hdr = r_hdr;
        if (i_acc) begin
            case (r_phase)
                PH_SYNC1: if (i_byte == i_cfg.sync_first) n_sum = i_byte;
                PH_SYNC2: if (i_byte == i_cfg.sync_second) n_sum = r_sum + i_byte;
                PH_DEV: begin
                    n_hdr.dev = i_byte;
                    n_sum     = r_sum + i_byte;
                end
                PH_SYS: begin
                    n_hdr.sys = i_byte;
                    n_sum     = r_sum + i_byte;
                end
                PH_MSG: begin
                    n_hdr.msg = i_byte;
                    n_sum     = r_sum + i_byte;
                end
                PH_LEN: begin
                    n_cnt = '0;
                    if (!len_bad) begin
                        n_hdr.len = i_byte[LEN_W-1:0];
                        n_sum     = r_sum + i_byte;
                    end
                end
                PH_DATA: begin
                    n_cnt = cnt_inc;
                    n_sum = r_sum + i_byte;
                end
                default: n_cnt = '0;
            endcase
        end
    end

    // Outputs.
    always_comb begin
        o_wr.we   = i_acc && (r_phase == PH_DATA);
        o_wr.addr = r_cnt[ADDR_W-1:0];
        o_wr.data = i_byte;
        o_start   = i_acc && (r_phase == PH_CSUM) && (i_byte == r_sum);
        o_hdr     = r_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

`default_nettype wire

### rtl/core/slcfp_replay.sv
// Replay sequencer: reads stored payload bytes and drives the result register.
// Depends on slcfp_pkg and slcfp_out_if.
`default_nettype none

module slcfp_replay (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire slcfp_pkg::t_frame_hdr        i_hdr,
    output slcfp_pkg::t_ram_rd                o_rd,
    input  wire logic [slcfp_pkg::BYTE_W-1:0] i_rd_data,
    output logic                              o_busy,
    slcfp_out_if.source                       o_res
);
    import slcfp_pkg::*;

    logic              r_busy;
    t_frame_hdr        r_hdr;
    logic [LEN_W-1:0]  r_idx;

    // Read stage: one transaction whose RAM data arrives in the next cycle.
    logic              r_rd_v;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_rd_has;
    logic              r_rd_last;

    logic              r_out_v;
    t_frame_hdr        r_out_hdr;
    logic [BIDX_W-1:0] r_out_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_has;
    logic              r_out_last;

    logic load, issue, issue_last, has_data;

    assign has_data   = (r_hdr.len != '0);
    assign load       = r_rd_v && (!r_out_v || o_res.ready);
    assign issue      = r_busy && (!r_rd_v || load);
    assign issue_last = !has_data || ((r_idx + LEN_W'(1)) == r_hdr.len);

    assign o_rd.en   = issue && has_data;
    assign o_rd.addr = r_idx[ADDR_W-1:0];
    assign o_busy    = r_busy || r_rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (issue) begin
                r_idx <= r_idx + LEN_W'(1);
                if (issue_last) begin
                    r_busy <= 1'b0;
                end
            end

            if (issue) begin
                r_rd_v <= 1'b1;
            end else if (load) begin
                r_rd_v <= 1'b0;
            end

            if (load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hdr <= i_hdr;
        end
        if (issue) begin
            r_rd_idx  <= r_idx[ADDR_W-1:0];
            r_rd_has  <= has_data;
            r_rd_last <= issue_last;
        end
        if (load) begin
            r_out_hdr  <= r_hdr;
            r_out_idx  <= BIDX_W'(r_rd_idx);
            r_out_byte <= r_rd_has ? i_rd_data : '0;
            r_out_has  <= r_rd_has;
            r_out_last <= r_rd_last;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.device_id    = r_out_hdr.dev;
    assign o_res.system_id    = r_out_hdr.sys;
    assign o_res.message_id   = r_out_hdr.msg;
    assign o_res.payload_len  = r_out_hdr.len;
    assign o_res.byte_index   = r_out_idx;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.has_byte     = r_out_has;
    assign o_res.last         = r_out_last;

endmodule

`default_nettype wire

### rtl/core/sync_length_checksum_frame_parser_top.sv
// Top level of the two-sync-byte framed parser with additive checksum.
// Depends on slcfp_pkg, slcfp_if, slcfp_payload_ram, slcfp_rx_fsm, slcfp_replay.
//
//   Port       Dir  Handshake          Carries
//   i_rx       in   valid/ready        rx_byte
//   o_res      out  valid/ready        header, byte_index, payload_byte, has_byte, last
//   i_cfg_*    in   write enable only  register index and write data
//
// A received byte is taken whenever no replay is running.
// A good checksum byte starts a replay of max(len,1) results, one per cycle while
// the output is not stalled, paced by the single read port of the payload RAM;
// bytes are held off until the last result has moved into the output register.
// Reset is synchronous and needs no clearing pass; a stalled output holds its result.
`default_nettype none

module sync_length_checksum_frame_parser_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    slcfp_in_if.sink                             i_rx,
    slcfp_out_if.source                          o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [slcfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [slcfp_pkg::BYTE_W-1:0]    i_cfg_wdata
);
    import slcfp_pkg::*;

    t_cfg              r_cfg;
    t_ram_wr           ram_wr;
    t_ram_rd           ram_rd;
    logic [BYTE_W-1:0] ram_rd_data;
    t_frame_hdr        hdr;
    logic              start;
    logic              busy;
    logic              rx_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.max_len     <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_wdata;
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_wdata;
                REG_MAX_LEN:     r_cfg.max_len     <= i_cfg_wdata[LEN_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign i_rx.ready = !busy;
    assign rx_acc     = i_rx.valid && !busy;

    slcfp_rx_fsm u_rx_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (rx_acc),
        .i_byte  (i_rx.rx_byte),
        .i_cfg   (r_cfg),
        .o_wr    (ram_wr),
        .o_start (start),
        .o_hdr   (hdr)
    );

    slcfp_payload_ram u_payload_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (ram_rd_data)
    );

    slcfp_replay u_replay (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_hdr     (hdr),
        .o_rd      (ram_rd),
        .i_rd_data (ram_rd_data),
        .o_busy    (busy),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

### tb/tb_sync_length_checksum_frame_parser_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_checksum_frame_parser_top: random frames, a shadow parser.
// Depends on slcfp_pkg, the channel interfaces in slcfp_if and the parser RTL.

module tb_sync_length_checksum_frame_parser_top;
    import slcfp_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 64;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] system_id;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_len;
        logic [BIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic              last;
    } t_replay;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_wdata;

    slcfp_in_if  rx_if ();
    slcfp_out_if res_if ();

    sync_length_checksum_frame_parser_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [BYTE_W-1:0] tx_bytes[$];
    t_replay           expected_replay[$];
    int                err_count    = 0;
    int                idle_pct     = 10;
    int                stall_cycles = 0;

    // Shadow copy of the parser state and its registers.
    t_cfg              cfg;
    t_phase            ph;
    t_frame_hdr        hdr;
    logic [LEN_W-1:0]  rcount;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] store[MAX_PAYLOAD];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A register value above the payload store size acts as the store size.
    function automatic logic [LEN_W-1:0] len_limit();
        return (cfg.max_len > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : cfg.max_len;
    endfunction

    // Advances the shadow parser by one received byte and queues the replay
    // that a good checksum byte causes.
    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        t_replay r;
        int      i;
        case (ph)
            PH_SYNC1: begin
                if (b == cfg.sync_first) begin
                    csum = b;
                    ph   = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (b == cfg.sync_second) begin
                    csum = csum + b;
                    ph   = PH_DEV;
                end else begin
                    ph = PH_SYNC1;
                end
            end
            PH_DEV: begin
                hdr.dev = b;
                csum    = csum + b;
                ph      = PH_SYS;
            end
            PH_SYS: begin
                hdr.sys = b;
                csum    = csum + b;
                ph      = PH_MSG;
            end
            PH_MSG: begin
                hdr.msg = b;
                csum    = csum + b;
                ph      = PH_LEN;
            end
            PH_LEN: begin
                rcount = '0;
                if (b > len_limit()) begin
                    ph = PH_SYNC1;
                end else begin
                    hdr.len = b[LEN_W-1:0];
                    csum    = csum + b;
                    ph      = (b == 0) ? PH_CSUM : PH_DATA;
                end
            end
            PH_DATA: begin
                store[rcount[BIDX_W-1:0]] = b;
                csum   = csum + b;
                rcount = rcount + 1'b1;
                if (rcount >= hdr.len) begin
                    rcount = '0;
                    ph     = PH_CSUM;
                end
            end
            default: begin
                if (b == csum) begin
                    r.device_id   = hdr.dev;
                    r.system_id   = hdr.sys;
                    r.message_id  = hdr.msg;
                    r.payload_len = hdr.len;
                    if (hdr.len == 0) begin
                        r.byte_index   = '0;
                        r.payload_byte = '0;
                        r.has_byte     = 1'b0;
                        r.last         = 1'b1;
                        expected_replay.push_back(r);
                    end else begin
                        for (i = 0; i < hdr.len; i++) begin
                            r.byte_index   = BIDX_W'(i);
                            r.payload_byte = store[i];
                            r.has_byte     = 1'b1;
                            r.last         = (i + 1 == hdr.len);
                            expected_replay.push_back(r);
                        end
                    end
                end
                ph     = PH_SYNC1;
                rcount = '0;
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic cmp_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_replay e;
        if (expected_replay.size() == 0) begin
            report_error($sformatf("unexpected result dev 0x%0h msg 0x%0h index %0d",
                                   res_if.device_id, res_if.message_id, res_if.byte_index));
            return;
        end
        e = expected_replay.pop_front();
        cmp_field("device_id", res_if.device_id, e.device_id);
        cmp_field("system_id", res_if.system_id, e.system_id);
        cmp_field("message_id", res_if.message_id, e.message_id);
        cmp_field("payload_len", res_if.payload_len, e.payload_len);
        cmp_field("byte_index", res_if.byte_index, e.byte_index);
        cmp_field("payload_byte", res_if.payload_byte, e.payload_byte);
        cmp_field("has_byte", res_if.has_byte, e.has_byte);
        cmp_field("last", res_if.last, e.last);
    endtask

    // Byte driver: a new transaction is offered only once the previous one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                parse_byte(rx_if.rx_byte);
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= tx_bytes.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
            res_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg.sync_first  = val;
            REG_SYNC_SECOND: cfg.sync_second = val;
            REG_MAX_LEN:     cfg.max_len     = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Checked at the falling edge so that all updates of the rising edge have landed.
    task automatic wait_idle();
        while (tx_bytes.size() != 0 || rx_if.valid || expected_replay.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // An oversize length ends the frame at the length byte, so nothing follows it.
    task automatic push_frame(input logic [BYTE_W-1:0] dev, sys, msg, len, input bit good);
        logic [BYTE_W-1:0] total;
        logic [BYTE_W-1:0] d;
        total = cfg.sync_first + cfg.sync_second + dev + sys + msg + len;
        tx_bytes.push_back(cfg.sync_first);
        tx_bytes.push_back(cfg.sync_second);
        tx_bytes.push_back(dev);
        tx_bytes.push_back(sys);
        tx_bytes.push_back(msg);
        tx_bytes.push_back(len);
        if (len <= len_limit()) begin
            repeat (len) begin
                d     = 8'($urandom);
                total = total + d;
                tx_bytes.push_back(d);
            end
            tx_bytes.push_back(good ? total : total + 8'($urandom_range(255, 1)));
        end
    endtask

    task automatic push_random_frame();
        int kind;
        int lim;
        int len;
        kind = $urandom_range(99);
        lim  = len_limit();
        if ($urandom_range(19) == 0) begin
            len = lim;
        end else begin
            len = $urandom_range((lim < 8) ? lim : 8);
        end
        if (kind < 72) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'(len), 1'b1);
        end else if (kind < 82) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'(len), 1'b0);
        end else if (kind < 88) begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom_range(255, lim + 1)), 1'b1);
        end else if (kind < 94) begin
            tx_bytes.push_back(cfg.sync_first);
            tx_bytes.push_back(cfg.sync_second + 8'($urandom_range(255, 1)));
        end else begin
            repeat ($urandom_range(4, 1)) tx_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic random_phase(input int nbytes);
        while (tx_bytes.size() < nbytes) begin
            push_random_frame();
        end
        wait_idle();
    endtask

    initial begin
        logic [LEN_W-1:0] mlen;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_SYNC_FIRST;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        cfg.sync_first  = SYNC_FIRST_RST;
        cfg.sync_second = SYNC_SECOND_RST;
        cfg.max_len     = MAX_LEN_RST;
        ph     = PH_SYNC1;
        hdr    = '0;
        rcount = '0;
        csum   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the registers: short directed frames.
        push_frame(8'h00, 8'h00, 8'h00, 8'd0, 1'b1);
        push_frame(8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b1);
        push_frame(8'h12, 8'h34, 8'h56, 8'd3, 1'b0);
        // A first sync byte followed by another: the second one fails as the
        // second sync and is not taken as a new start, so the frame is lost.
        tx_bytes.push_back(cfg.sync_first);
        push_frame(8'h01, 8'h02, 8'h03, 8'd2, 1'b1);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h00);
        push_frame(8'h21, 8'h22, 8'h23, 8'd65, 1'b1);
        push_frame(8'h31, 8'h32, 8'h33, 8'd4, 1'b1);
        wait_idle();

        // Only zero-length frames pass.
        write_reg(REG_SYNC_FIRST, 8'h00);
        write_reg(REG_SYNC_SECOND, 8'hFF);
        write_reg(REG_MAX_LEN, 8'd0);
        push_frame(8'hA5, 8'h5A, 8'hC3, 8'd0, 1'b1);
        push_frame(8'hA5, 8'h5A, 8'hC3, 8'd1, 1'b1);
        random_phase(RANDOM_BYTES);

        // A register above the store size is clamped to it.
        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'h00);
        write_reg(REG_MAX_LEN, 8'd127);
        push_frame(8'h80, 8'h40, 8'h20, 8'd64, 1'b1);
        push_frame(8'h80, 8'h40, 8'h20, 8'd65, 1'b1);
        random_phase(RANDOM_BYTES);

        // Equal sync bytes, no idling on either side, and a write to an unmapped index.
        idle_pct = 0;
        mlen     = LEN_W'($urandom_range(63, 1));
        write_reg(REG_SYNC_FIRST, 8'h5A);
        write_reg(REG_SYNC_SECOND, 8'h5A);
        write_reg(REG_MAX_LEN, 8'(mlen));
        write_reg(REG_UNMAPPED, 8'hFF);
        push_frame(8'h11, 8'h22, 8'h33, 8'(mlen), 1'b1);
        push_frame(8'h11, 8'h22, 8'h33, 8'(mlen) + 8'd1, 1'b1);
        random_phase(RANDOM_BYTES);
        idle_pct = 10;

        write_reg(REG_SYNC_FIRST, 8'($urandom));
        write_reg(REG_SYNC_SECOND, 8'($urandom));
        write_reg(REG_MAX_LEN, 8'($urandom_range(64, 1)));
        random_phase(RANDOM_BYTES);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/slcfp_pkg.sv
rtl/core/slcfp_if.sv
rtl/core/slcfp_payload_ram.sv
rtl/core/slcfp_rx_fsm.sv
rtl/core/slcfp_replay.sv
rtl/core/sync_length_checksum_frame_parser_top.sv
tb/tb_sync_length_checksum_frame_parser_top.sv
